/* hw/rtl/bscw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscw_pkg: shared definitions of the bottom-up image crop window
// Register indexes, field widths, image limits and the job record that
// travels from the classifier to the result expander.
// ----------------------------------------------------------------------------
package bscw_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int REG_W   = 13;  // configuration register width
  localparam int COL_W   = 14;  // byte column counter width
  localparam int ROW_W   = 12;  // stored row counter width
  localparam int IDX_W   = 3;   // configuration register index width
  localparam int QDEPTH  = 4;   // job queue depth
  localparam int QPTR_W  = 2;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CROP_LEFT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROP_TOP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROP_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROP_HEIGHT = 3'd5;

  // One accepted item that yields results: the kept byte or an error marker,
  // plus the number of padding bytes that follow it.
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic [1:0] npad;
    logic       done;
  } job_t;

endpackage

/* hw/rtl/bscw_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscw_classifier: front end of the crop window
// Holds the configuration registers and the row and column counters, and
// turns each accepted source byte into a job or into nothing.
// ----------------------------------------------------------------------------
module bscw_classifier (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [bscw_pkg::IDX_W-1:0] cfg_index,
  input  logic [bscw_pkg::REG_W-1:0] cfg_data,
  input  logic                      accept,
  input  logic [7:0]                source_byte,
  input  logic                      image_start,
  output logic                      job_valid,
  output bscw_pkg::job_t            job
);
  import bscw_pkg::*;

  logic [REG_W-1:0] src_width, src_height, crop_left, crop_top, crop_width, crop_height;
  logic [COL_W-1:0] byte_column;
  logic [ROW_W-1:0] stored_row;
  logic             finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= REG_W'(1);
      src_height  <= REG_W'(1);
      crop_left   <= '0;
      crop_top    <= '0;
      crop_width  <= REG_W'(1);
      crop_height <= REG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_width   <= cfg_data;
        REG_SRC_HEIGHT:  src_height  <= cfg_data;
        REG_CROP_LEFT:   crop_left   <= cfg_data;
        REG_CROP_TOP:    crop_top    <= cfg_data;
        REG_CROP_WIDTH:  crop_width  <= cfg_data;
        REG_CROP_HEIGHT: crop_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window geometry, all derived from the registers.
  logic              bad;
  logic [REG_W:0]    h_sum, w_sum;
  logic [REG_W-1:0]  first_row, last_row;
  logic [COL_W:0]    row_bytes, col_lo, col_hi;
  logic [1:0]        pad;

  assign w_sum = {1'b0, crop_left} + {1'b0, crop_width};
  assign h_sum = {1'b0, crop_top} + {1'b0, crop_height};
  assign bad = (src_width > REG_W'(MAX_WIDTH)) || (src_height > REG_W'(MAX_HEIGHT)) ||
               (crop_width == '0) || (crop_height == '0) ||
               (w_sum > {1'b0, src_width}) || (h_sum > {1'b0, src_height});
  assign first_row = src_height - crop_height - crop_top;
  assign last_row  = src_height - REG_W'(1) - crop_top;
  assign row_bytes = (COL_W+1)'({src_width, 1'b0}) + (COL_W+1)'(src_width)
                   + (COL_W+1)'(src_width[1:0]);
  assign col_lo    = (COL_W+1)'({crop_left, 1'b0}) + (COL_W+1)'(crop_left);
  assign col_hi    = col_lo + (COL_W+1)'({crop_width, 1'b0}) + (COL_W+1)'(crop_width)
                   - (COL_W+1)'(1);
  assign pad       = crop_width[1:0];

  // A start marker clears the counters before this byte is placed.
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;
  logic             fin_eff, hit, row_end, done, wrap;

  assign col_eff = image_start ? '0 : byte_column;
  assign row_eff = image_start ? '0 : stored_row;
  assign fin_eff = image_start ? 1'b0 : finished;
  assign hit = ({1'b0, row_eff} >= first_row) && ({1'b0, row_eff} <= last_row) &&
               ({1'b0, col_eff} >= col_lo) && ({1'b0, col_eff} <= col_hi);
  assign row_end = ({1'b0, col_eff} == col_hi);
  assign done    = row_end && ({1'b0, row_eff} == last_row);
  assign wrap    = ({1'b0, col_eff} + (COL_W+1)'(1)) >= row_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      stored_row  <= '0;
      finished    <= 1'b0;
    end else if (accept) begin
      if (bad || fin_eff) begin
        byte_column <= col_eff;
        stored_row  <= row_eff;
        finished    <= fin_eff;
      end else begin
        finished <= hit && done;
        if (wrap) begin
          byte_column <= '0;
          stored_row  <= row_eff + ROW_W'(1);
        end else begin
          byte_column <= col_eff + COL_W'(1);
          stored_row  <= row_eff;
        end
      end
    end
  end

  assign job_valid = accept && (bad || (!fin_eff && hit));
  assign job.data  = bad ? 8'd0 : source_byte;
  assign job.err   = bad;
  assign job.npad  = (!bad && row_end) ? pad : 2'd0;
  assign job.done  = !bad && done;

endmodule

/* hw/rtl/bscw_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscw_job_queue: job queue between classifier and expander
// A small register queue that lets the front accept bytes while the back
// is still writing out padding.
// ----------------------------------------------------------------------------
module bscw_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bscw_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd,
  output logic           nonempty,
  output bscw_pkg::job_t rd_job
);
  import bscw_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr) else $error("job written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> !rd) else $error("job read from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

/* hw/rtl/bscw_expander.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bscw_expander: back end of the crop window
// Turns each queued job into its kept byte and its padding bytes, one
// result item per cycle while the output is free, into the output register.
// ----------------------------------------------------------------------------
module bscw_expander (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  bscw_pkg::job_t job,
  output logic           job_take,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     crop_byte,
  output logic           is_padding,
  output logic           run_last,
  output logic           crop_done,
  output logic           window_error
);
  import bscw_pkg::*;

  logic       out_valid;
  logic [1:0] sub;   // which result of the head job comes next
  logic       load, res_last;

  assign empty    = !out_valid;
  assign load     = job_avail && (!out_valid || pop);
  assign res_last = job.err || (sub == job.npad);
  assign job_take = load && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= res_last ? 2'd0 : sub + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crop_byte    <= (sub == 2'd0) ? job.data : 8'd0;
      is_padding   <= (sub != 2'd0);
      run_last     <= res_last;
      crop_done    <= job.done && res_last;
      window_error <= job.err;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(crop_byte) && $stable(run_last))
    else $error("waiting result item changed");
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_error |-> run_last && !is_padding && !crop_done)
    else $error("malformed error result");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && crop_done |-> run_last) else $error("crop_done without run_last");

endmodule

/* hw/rtl/bmp_stream_crop_window_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_crop_window_core: streaming crop of 24-bit bottom-up pixel data
// Counts byte column and stored row of the incoming pixel bytes, keeps the
// bytes inside the crop window and appends row padding for the new width.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// input     in         push / full            source_byte, image_start
// result    out        empty / pop            crop_byte, is_padding, run_last,
//                                             crop_done, window_error
// config    in         cfg_write (no wait)    cfg_index, cfg_data
//
// An input item can be accepted every cycle while the job queue has room.
// A kept byte goes through the job queue into the output register.
// The expander writes one result item per cycle while results are taken; a
// kept byte at a row end makes up to four results, so across row ends the
// input rate is set by the expander; the four-entry job queue absorbs that burst.
// Reset (rst, synchronous) restores the register defaults, clears counters
// and empties the queue and output register; there is no clearing pass.
// Either side may stall at any time without loss: full rises only when the
// queue holds four jobs, and a waiting result stays until it is popped.
// ----------------------------------------------------------------------------
module bmp_stream_crop_window_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bscw_pkg::IDX_W-1:0] cfg_index,
  input  logic [bscw_pkg::REG_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 source_byte,
  input  logic                       image_start,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 crop_byte,
  output logic                       is_padding,
  output logic                       run_last,
  output logic                       crop_done,
  output logic                       window_error
);
  import bscw_pkg::*;

  logic accept;
  logic job_valid, q_nonempty, q_take;
  job_t new_job, head_job;

  // The front only sees a byte once the queue can hold whatever it yields.
  assign accept = push && !full;

  bscw_classifier u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .source_byte (source_byte),
    .image_start (image_start),
    .job_valid   (job_valid),
    .job         (new_job)
  );

  // Jobs wait here while the back is busy writing padding or is stalled.
  bscw_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_valid),
    .wr_job   (new_job),
    .full     (full),
    .rd       (q_take),
    .nonempty (q_nonempty),
    .rd_job   (head_job)
  );

  bscw_expander u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (q_nonempty),
    .job          (head_job),
    .job_take     (q_take),
    .pop          (pop),
    .empty        (empty),
    .crop_byte    (crop_byte),
    .is_padding   (is_padding),
    .run_last     (run_last),
    .crop_done    (crop_done),
    .window_error (window_error)
  );

endmodule
